// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the pipeline control and the top level of the tick count to date converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge and disabled during reset.
`define ASSERT_IMPL(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising edge and disabled during reset.
`define ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tcc_pkg.sv
// Package with the widths, constants and types of the tick count to date converter.
package tcc_pkg;

  localparam int TICK_W  = 62;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  localparam int NUM_STAGES   = 14;
  localparam int SPLIT_STAGES = 4;
  localparam int DATE_STAGES  = NUM_STAGES - SPLIT_STAGES;

  localparam logic [TICK_W-1:0] MAX_TICKS = 62'd3155378975999999999;

  localparam int DAYS_W    = 22;
  localparam int DAY_REM_W = 26;
  localparam int FRAC_W    = 7;

  localparam logic [25:0] DAY_DIV   = 26'd52734375;
  localparam logic [24:0] DAY_RECIP = 25'((64'd1 << 50) / 64'd52734375);

  localparam logic [33:0] SEC_RECIP  = 34'(((64'd1 << 50) + 64'd78124) / 64'd78125);
  localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MIN_RECIP  = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

  localparam logic [22:0] JD_OFFSET    = 23'(1721426 + 68569);
  localparam logic [24:0] CYCLE_DAYS   = 25'd146097;
  localparam logic [25:0] CYCLE_RECIP  = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
  localparam logic [28:0] YEAR_RECIP   = 29'(((64'd1 << 49) + 64'd1461000) / 64'd1461001);
  localparam logic [16:0] MONTH_RECIP  = 17'(((64'd1 << 28) + 64'd2446) / 64'd2447);
  localparam logic [16:0] DIV80_RECIP  = 17'(((64'd1 << 23) + 64'd79) / 64'd80);

  typedef struct packed {
    logic [DAYS_W-1:0]    days;
    logic [DAY_REM_W-1:0] rem;
    logic [FRAC_W-1:0]    frac;
  } split_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } tod_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
  } date_t;

endpackage

// File: hw/rtl/tcc_pipe_ctrl.sv
// Valid bits and per-stage load enables of the converter pipeline.
`include "assert_macros.svh"

module tcc_pipe_ctrl import tcc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [NUM_STAGES-1:0] en
);

  logic [NUM_STAGES-1:0] v;

  assign en[NUM_STAGES-1] = !v[NUM_STAGES-1] || !out_stall;

  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NUM_STAGES-1];

  `ASSERT_IMPL(a_stall_only_when_full, clk, rst, in_stall, &v, "Input stalled with an empty stage.")
  `ASSERT_NEXT(a_request_enters, clk, rst, in_valid && !in_stall, v[0], "Accepted request was lost.")
  `ASSERT_NEXT(a_last_stage_fills, clk, rst, v[NUM_STAGES-2] && en[NUM_STAGES-1], out_valid, "Result did not reach the output stage.")

endmodule

// File: hw/rtl/tcc_day_split.sv
// Clamp and division of the tick count into whole days and the remaining ticks.
module tcc_day_split import tcc_pkg::*; (
  input  logic                    clk,
  input  logic [SPLIT_STAGES-1:0] en,
  input  logic [TICK_W-1:0]       tick_count,
  output split_t                  split
);

  logic [TICK_W-1:0] tick_1;
  logic [DAYS_W-1:0] est_2;
  logic [54:0]       x_2;
  logic [26:0]       rraw_3;
  logic [DAYS_W-1:0] est_3;
  logic [FRAC_W-1:0] frac_3;

  logic [TICK_W-1:0] tick_next;
  logic [56:0]       est_prod;
  logic [26:0]       rraw_next;
  split_t            split_next;

  always_comb begin
    tick_next = (tick_count > MAX_TICKS) ? MAX_TICKS : tick_count;
    est_prod  = 57'(tick_1[61:30]) * 57'(DAY_RECIP);
    rraw_next = 27'(x_2[54:7] - 48'(est_2) * 48'(DAY_DIV));
    split_next.frac = frac_3;
    if (rraw_3 >= 27'(DAY_DIV)) begin
      split_next.days = est_3 + 22'd1;
      split_next.rem  = 26'(rraw_3 - 27'(DAY_DIV));
    end else begin
      split_next.days = est_3;
      split_next.rem  = rraw_3[25:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tick_1 <= tick_next;
    end
    if (en[1]) begin
      est_2 <= est_prod[55:34];
      x_2   <= tick_1[61:7];
    end
    if (en[2]) begin
      rraw_3 <= rraw_next;
      est_3  <= est_2;
      frac_3 <= x_2[6:0];
    end
    if (en[3]) begin
      split <= split_next;
    end
  end

endmodule

// File: hw/rtl/tcc_time_of_day.sv
// Hour, minute and second from the ticks left over after whole days.
module tcc_time_of_day import tcc_pkg::*; (
  input  logic                   clk,
  input  logic [DATE_STAGES-1:0] en,
  input  logic [DAY_REM_W-1:0]   rem,
  input  logic [FRAC_W-1:0]      frac,
  output tod_t                   tod
);

  localparam int CALC_STAGES = 5;
  localparam int TOD_DELAY   = DATE_STAGES - CALC_STAGES;

  logic [16:0]       sod_1;
  logic [16:0]       sod_2;
  logic [HOUR_W-1:0] hour_2;
  logic [11:0]       ms_3;
  logic [HOUR_W-1:0] hour_3;
  logic [11:0]       ms_4;
  logic [MIN_W-1:0]  minute_4;
  logic [HOUR_W-1:0] hour_4;
  tod_t              tod_q [TOD_DELAY+1];

  logic [66:0] sod_prod;
  logic [34:0] hour_prod;
  logic [24:0] min_prod;
  logic [11:0] ms_next;
  tod_t        tod_next;

  always_comb begin
    sod_prod        = 67'({rem, frac}) * 67'(SEC_RECIP);
    hour_prod       = 35'(sod_1) * 35'(HOUR_RECIP);
    ms_next         = 12'(sod_2 - 17'(hour_2) * 17'd3600);
    min_prod        = 25'(ms_3) * 25'(MIN_RECIP);
    tod_next.hour   = hour_4;
    tod_next.minute = minute_4;
    tod_next.second = 6'(ms_4 - 12'(minute_4) * 12'd60);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sod_1 <= sod_prod[66:50];
    end
    if (en[1]) begin
      sod_2  <= sod_1;
      hour_2 <= hour_prod[33:29];
    end
    if (en[2]) begin
      ms_3   <= ms_next;
      hour_3 <= hour_2;
    end
    if (en[3]) begin
      ms_4     <= ms_3;
      minute_4 <= min_prod[23:18];
      hour_4   <= hour_3;
    end
    if (en[4]) begin
      tod_q[0] <= tod_next;
    end
    for (int i = 1; i <= TOD_DELAY; i++) begin
      if (en[CALC_STAGES-1+i]) begin
        tod_q[i] <= tod_q[i-1];
      end
    end
  end

  assign tod = tod_q[TOD_DELAY];

endmodule

// File: hw/rtl/tcc_civil_date.sv
// Gregorian year, month and day from the whole day count.
module tcc_civil_date import tcc_pkg::*; (
  input  logic                   clk,
  input  logic [DATE_STAGES-1:0] en,
  input  logic [DAYS_W-1:0]      days,
  output date_t                  date
);

  logic [22:0]        a_1;
  logic [22:0]        a_2;
  logic [7:0]         c_2;
  logic [15:0]        a2_3;
  logic [7:0]         c_3;
  logic [27:0]        n_4;
  logic [15:0]        a2_4;
  logic [7:0]         c_4;
  logic [6:0]         yr_5;
  logic [15:0]        a2_5;
  logic [7:0]         c_5;
  logic [8:0]         a3_6;
  logic [YEAR_W-1:0]  yb_6;
  logic [15:0]        n2_7;
  logic [8:0]         a3_7;
  logic [YEAR_W-1:0]  yb_7;
  logic [MONTH_W-1:0] mo_8;
  logic [8:0]         a3_8;
  logic [YEAR_W-1:0]  yb_8;
  logic [15:0]        m2_9;
  logic [MONTH_W-1:0] mo_9;
  logic [8:0]         a3_9;
  logic [YEAR_W-1:0]  yb_9;

  logic [50:0]       c_prod;
  logic [24:0]       cyc_sum;
  logic [15:0]       a2_next;
  logic [27:0]       n_next;
  logic [56:0]       yr_prod;
  logic [17:0]       yd_prod;
  logic [8:0]        a3_next;
  logic [YEAR_W-1:0] yb_next;
  logic [32:0]       mo_prod;
  logic [32:0]       d80_prod;
  logic [8:0]        d80;
  logic              wrap;
  date_t             date_next;

  always_comb begin
    c_prod   = 51'({a_1, 2'b00}) * 51'(CYCLE_RECIP);
    cyc_sum  = 25'(c_2) * CYCLE_DAYS + 25'd3;
    a2_next  = 16'(a_2 - cyc_sum[24:2]);
    n_next   = (28'(a2_3) + 28'd1) * 28'd4000;
    yr_prod  = 57'(n_4) * 57'(YEAR_RECIP);
    yd_prod  = 18'(yr_5) * 18'd1461;
    a3_next  = 9'(17'(a2_5) + 17'd31 - 17'(yd_prod[17:2]));
    yb_next  = (14'(c_5) - 14'd49) * 14'd100 + 14'(yr_5);
    mo_prod  = 33'(n2_7) * 33'(MONTH_RECIP);
    d80_prod = 33'(m2_9) * 33'(DIV80_RECIP);
    d80      = d80_prod[31:23];
    wrap     = (mo_9 >= 4'd11);
    date_next.day_of_month = 5'(a3_9 - d80);
    date_next.month        = wrap ? (mo_9 - 4'd10) : (mo_9 + 4'd2);
    date_next.year         = yb_9 + 14'(wrap);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_1 <= 23'(days) + JD_OFFSET;
    end
    if (en[1]) begin
      a_2 <= a_1;
      c_2 <= c_prod[50:43];
    end
    if (en[2]) begin
      a2_3 <= a2_next;
      c_3  <= c_2;
    end
    if (en[3]) begin
      n_4  <= n_next;
      a2_4 <= a2_3;
      c_4  <= c_3;
    end
    if (en[4]) begin
      yr_5 <= yr_prod[55:49];
      a2_5 <= a2_4;
      c_5  <= c_4;
    end
    if (en[5]) begin
      a3_6 <= a3_next;
      yb_6 <= yb_next;
    end
    if (en[6]) begin
      n2_7 <= 16'(a3_6) * 16'd80;
      a3_7 <= a3_6;
      yb_7 <= yb_6;
    end
    if (en[7]) begin
      mo_8 <= mo_prod[31:28];
      a3_8 <= a3_7;
      yb_8 <= yb_7;
    end
    if (en[8]) begin
      m2_9 <= 16'(mo_8) * 16'd2447;
      mo_9 <= mo_8;
      a3_9 <= a3_8;
      yb_9 <= yb_8;
    end
    if (en[9]) begin
      date <= date_next;
    end
  end

endmodule

// File: hw/rtl/tick_count_to_calendar_date_time.sv
// Top level of the converter from a 100 ns tick count to Gregorian date and time of day.
//
// One request carries tick_count, the number of 100 ns ticks since midnight at the start
// of 1 January of year 1. The result carries year, month, day_of_month, hour, minute and
// second. Counts past the end of year 9999 give 9999-12-31 23:59:59, and fractions of a
// second are dropped.
// Both channels use valid and stall: a transfer happens at a clock edge with valid high
// and stall low. The block is a 14-stage pipeline with one valid bit per stage, so one
// request is taken in every cycle while in_stall is low. The stages hold the day split
// and the chain of constant-reciprocal multiplies in the date path.
// When out_stall holds a result, the stages behind it keep moving until they are full;
// in_stall rises only when every stage holds a request. Results leave in request order.
// A synchronous reset on rst empties the pipeline; data registers are not reset.
`include "assert_macros.svh"

module tick_count_to_calendar_date_time import tcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [TICK_W-1:0]  tick_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [YEAR_W-1:0]  year,
  output logic [MONTH_W-1:0] month,
  output logic [DAY_W-1:0]   day_of_month,
  output logic [HOUR_W-1:0]  hour,
  output logic [MIN_W-1:0]   minute,
  output logic [SEC_W-1:0]   second
);

  logic [NUM_STAGES-1:0] en;
  split_t                split;
  tod_t                  tod;
  date_t                 date;

  tcc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .en        (en)
  );

  tcc_day_split u_split (
    .clk        (clk),
    .en         (en[SPLIT_STAGES-1:0]),
    .tick_count (tick_count),
    .split      (split)
  );

  tcc_time_of_day u_tod (
    .clk  (clk),
    .en   (en[NUM_STAGES-1:SPLIT_STAGES]),
    .rem  (split.rem),
    .frac (split.frac),
    .tod  (tod)
  );

  tcc_civil_date u_date (
    .clk  (clk),
    .en   (en[NUM_STAGES-1:SPLIT_STAGES]),
    .days (split.days),
    .date (date)
  );

  assign year         = date.year;
  assign month        = date.month;
  assign day_of_month = date.day_of_month;
  assign hour         = tod.hour;
  assign minute       = tod.minute;
  assign second       = tod.second;

  `ASSERT_IMPL(a_date_range, clk, rst, out_valid, month >= 4'd1 && month <= 4'd12 && day_of_month != 5'd0 && year != 14'd0, "Result date out of range.")
  `ASSERT_IMPL(a_time_range, clk, rst, out_valid, hour < 5'd24 && minute < 6'd60 && second < 6'd60, "Result time of day out of range.")

endmodule
